// ----- sv/fpr_pkg.sv -----
// Shared types and constants for the FIFO page replacement unit.
package fpr_pkg;

  localparam int MaxFramesDef = 16;
  localparam int PageW        = 8;
  localparam int SlotW        = 4;
  localparam int CountW       = 32;
  localparam int CfgW         = 5;
  localparam logic [CfgW-1:0] FramesReset = 5'd4;

  typedef enum logic {
    ST_IDLE,
    ST_FULL
  } fpr_state_e;

  typedef struct packed {
    logic capture;
  } fpr_cmd_t;

endpackage

// ----- sv/fpr_ctrl.sv -----
// Handshake controller: owns item acceptance and the result-valid flag.
module fpr_ctrl
  import fpr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output fpr_cmd_t cmd_o
);

  fpr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o.capture = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_FULL;
        end
      end
      ST_FULL: begin
        out_valid_o   = 1'b1;
        in_ready_o    = out_ready_i;
        cmd_o.capture = in_valid_i && out_ready_i;
        if (out_ready_i && !in_valid_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_capture_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> out_valid_o)
    else $error("captured item produced no result");

  a_empty_is_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("empty result register but input stalled");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !cmd_o.capture)
    else $error("pending result overwritten");

endmodule

// ----- sv/fpr_datapath.sv -----
// Frame store, parallel lookup, FIFO pointer, fault counter and result register.
module fpr_datapath
  import fpr_pkg::*;
#(
  parameter int MaxFrames = MaxFramesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fpr_cmd_t          cmd_i,
  input  logic              cfg_we_i,
  input  logic [CfgW-1:0]   cfg_data_i,
  input  logic [PageW-1:0]  page_ref_i,
  output logic              hit_o,
  output logic [SlotW-1:0]  slot_o,
  output logic              evicted_valid_o,
  output logic [PageW-1:0]  evicted_page_o,
  output logic [CountW-1:0] fault_total_o
);

  localparam int IdxW = (MaxFrames > 1) ? $clog2(MaxFrames) : 1;
  localparam int NumW = $clog2(MaxFrames + 1);

  logic [CfgW-1:0]      frames_q;
  logic [PageW-1:0]     pages_q [MaxFrames];
  logic [MaxFrames-1:0] valid_q;
  logic [CountW-1:0]    faults_q;
  logic [IdxW-1:0]      ptr_q, ptr_d;

  logic [NumW-1:0]      active;
  logic [MaxFrames-1:0] match;
  logic                 found;
  logic [IdxW-1:0]      hit_idx;
  logic [IdxW-1:0]      fill_idx;
  logic [IdxW-1:0]      where;
  logic [31:0]          where_ext;
  logic [31:0]          inc_ext;

  always_comb begin
    if (frames_q == '0) begin
      active = NumW'(1);
    end else if (32'(frames_q) > 32'(MaxFrames)) begin
      active = NumW'(MaxFrames);
    end else begin
      active = NumW'(frames_q);
    end
  end

  always_comb begin
    for (int k = 0; k < MaxFrames; k++) begin
      match[k] = valid_q[k] && (pages_q[k] == page_ref_i) && (32'(k) < 32'(active));
    end
  end

  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    for (int k = MaxFrames - 1; k >= 0; k--) begin
      if (match[k]) begin
        found   = 1'b1;
        hit_idx = IdxW'(k);
      end
    end
  end

  assign fill_idx  = (32'(ptr_q) >= 32'(active)) ? '0 : ptr_q;
  assign where     = found ? hit_idx : fill_idx;
  assign where_ext = 32'(where);
  assign inc_ext   = 32'(fill_idx) + 32'd1;

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.capture && !found) begin
      ptr_d = (inc_ext >= 32'(active)) ? '0 : inc_ext[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= FramesReset;
      valid_q  <= '0;
      faults_q <= '0;
      ptr_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        frames_q <= cfg_data_i;
      end
      ptr_q <= ptr_d;
      if (cmd_i.capture && !found) begin
        valid_q[fill_idx] <= 1'b1;
        if (faults_q != '1) begin
          faults_q <= faults_q + CountW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && !found) begin
      pages_q[fill_idx] <= page_ref_i;
    end
  end

  // Result register; fault count shown after this item's update.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      hit_o           <= found;
      slot_o          <= where_ext[SlotW-1:0];
      evicted_valid_o <= !found && valid_q[fill_idx];
      evicted_page_o  <= (!found && valid_q[fill_idx]) ? pages_q[fill_idx] : '0;
      fault_total_o   <= (!found && faults_q != '1) ? faults_q + CountW'(1) : faults_q;
    end
  end

endmodule

// ----- sv/fifo_page_replacement.sv -----
// FIFO page replacement unit: top level joining controller and datapath.
// Result valid in the cycle after an item is accepted. The single result register drains
// and refills in the same cycle, so one item per cycle is taken while out_ready_i is high.
// Reset: all frames invalid, fault count and fill pointer zero, frames_q set to 4.
// Frame contents are not reset; an invalid frame never matches and never reports an eviction.
module fifo_page_replacement
  import fpr_pkg::*;
#(
  parameter int MaxFrames = MaxFramesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CfgW-1:0]   cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [PageW-1:0]  page_ref_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              hit_o,
  output logic [SlotW-1:0]  slot_o,
  output logic              evicted_valid_o,
  output logic [PageW-1:0]  evicted_page_o,
  output logic [CountW-1:0] fault_total_o
);

  fpr_cmd_t cmd;

  fpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  fpr_datapath #(
    .MaxFrames(MaxFrames)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .page_ref_i     (page_ref_i),
    .hit_o          (hit_o),
    .slot_o         (slot_o),
    .evicted_valid_o(evicted_valid_o),
    .evicted_page_o (evicted_page_o),
    .fault_total_o  (fault_total_o)
  );

endmodule

// ----- tb/fifo_page_replacement_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the FIFO page replacement unit.
module fifo_page_replacement_test;
  import fpr_pkg::*;

  typedef struct packed {
    logic              hit;
    logic [SlotW-1:0]  slot;
    logic              ev_valid;
    logic [PageW-1:0]  ev_page;
    logic [CountW-1:0] faults;
  } page_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CfgW-1:0]   cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [PageW-1:0]  page_ref_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              hit_o;
  logic [SlotW-1:0]  slot_o;
  logic              evicted_valid_o;
  logic [PageW-1:0]  evicted_page_o;
  logic [CountW-1:0] fault_total_o;

  fifo_page_replacement u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .page_ref_i      (page_ref_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .slot_o          (slot_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_total_o   (fault_total_o)
  );

  // Shadow copy of the replacement state.
  logic [CfgW-1:0]   frames_cfg = FramesReset;
  logic [PageW-1:0]  resident_page [MaxFramesDef];
  logic [MaxFramesDef-1:0] resident_valid = '0;
  logic [CountW-1:0] fault_tally = '0;
  int                next_victim = 0;

  logic [PageW-1:0]  page_queue[$];
  page_result_t      pending_results[$];
  logic [PageW-1:0]  hot_pages [20];
  int                hot_count;
  int                queued_count = 0;
  int                accepted_count = 0;
  int                errors = 0;
  int                idle_pct = 0;
  int                stall_pct = 0;
  bit                page_taken = 1'b0;

  function automatic int frames_active();
    if (frames_cfg == 0) return 1;
    if (frames_cfg > MaxFramesDef) return MaxFramesDef;
    return frames_cfg;
  endfunction

  function automatic page_result_t lookup_and_replace(input logic [PageW-1:0] page);
    page_result_t r;
    int active;
    int k;
    bit found;
    r = '0;
    found = 1'b0;
    active = frames_active();
    for (k = 0; k < active; k++) begin
      if (!found && resident_valid[k] && resident_page[k] == page) begin
        found = 1'b1;
        r.slot = k[SlotW-1:0];
      end
    end
    if (!found) begin
      if (next_victim >= active) next_victim = 0;
      r.slot = next_victim[SlotW-1:0];
      if (resident_valid[next_victim]) begin
        r.ev_valid = 1'b1;
        r.ev_page = resident_page[next_victim];
      end
      resident_page[next_victim] = page;
      resident_valid[next_victim] = 1'b1;
      next_victim = (next_victim + 1 >= active) ? 0 : next_victim + 1;
      if (fault_tally != '1) fault_tally = fault_tally + CountW'(1);
    end
    r.hit = found;
    r.faults = fault_tally;
    return r;
  endfunction

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("fifo_page_replacement_test: done, errors");
    $finish;
  end

  // Driver: inputs change on the falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= stall_pct);
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || page_taken) begin
      if (page_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_valid_i <= 1'b1;
        page_ref_i <= page_queue.pop_front();
      end else begin
        in_valid_i <= 1'b0;
        page_ref_i <= PageW'($urandom_range(255));
      end
    end
  end

  // Monitor: handshakes are sampled on the rising edge.
  always @(posedge clk_i) begin : monitor
    page_result_t want;
    page_result_t got;
    if (out_valid_o && out_ready_i) begin
      got = '{hit_o, slot_o, evicted_valid_o, evicted_page_o, fault_total_o};
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: hit=%0d slot=%0d ev=%0d/%0d faults=%0d",
                   got.hit, got.slot, got.ev_valid, got.ev_page, got.faults);
      end else begin
        want = pending_results.pop_front();
        if (got.hit !== want.hit || got.slot !== want.slot ||
            got.ev_valid !== want.ev_valid || got.ev_page !== want.ev_page ||
            got.faults !== want.faults) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: expected hit=%0d slot=%0d ev=%0d/%0d faults=%0d, ",
                      "got hit=%0d slot=%0d ev=%0d/%0d faults=%0d"},
                     want.hit, want.slot, want.ev_valid, want.ev_page, want.faults,
                     got.hit, got.slot, got.ev_valid, got.ev_page, got.faults);
        end
      end
    end
    page_taken = in_valid_i && in_ready_o;
    if (page_taken) begin
      pending_results.push_back(lookup_and_replace(page_ref_i));
      accepted_count++;
    end
  end

  task automatic enqueue(input logic [PageW-1:0] page);
    page_queue.push_back(page);
    queued_count++;
  endtask

  task automatic drain();
    while (!(page_queue.size() == 0 && accepted_count == queued_count &&
             pending_results.size() == 0))
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_frames(input logic [CfgW-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    frames_cfg = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_data_i <= CfgW'($urandom_range(31));
  endtask

  initial begin : stimulus
    int idle_mode [4];
    int stall_mode [4];
    logic [CfgW-1:0] extreme_cfg [8];
    int p;
    int n;
    int k;
    idle_mode = '{0, 50, 0, 29};
    stall_mode = '{0, 0, 50, 29};
    extreme_cfg = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd8, 5'd2, 5'd15};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Four frames out of reset: fills, hits, then evictions.
    enqueue(8'h00);
    enqueue(8'hff);
    enqueue(8'h00);
    enqueue(8'haa);
    enqueue(8'h55);
    enqueue(8'hff);
    enqueue(8'h01);
    enqueue(8'h02);
    drain();
    // Shrink below the fill pointer; frame 2 still holds 0xaa but is out of range.
    write_frames(5'd2);
    enqueue(8'haa);
    drain();
    // Grow back: 0xaa now sits in frames 0 and 2, lowest one wins.
    write_frames(5'd4);
    enqueue(8'haa);
    drain();
    write_frames(5'd0);
    enqueue(8'h07);
    enqueue(8'h07);
    enqueue(8'h08);
    drain();
    write_frames(5'd31);
    enqueue(8'h09);
    enqueue(8'hfe);
    enqueue(8'h09);
    drain();
    write_frames(5'd17);
    enqueue(8'h80);
    enqueue(8'h7f);
    drain();

    for (p = 0; p < 24; p++) begin
      write_frames(p < 8 ? extreme_cfg[p] : CfgW'($urandom_range(31)));
      idle_pct = idle_mode[p % 4];
      stall_pct = stall_mode[p % 4];
      hot_count = frames_active() + int'($urandom_range(0, 3));
      if (hot_count > 20) hot_count = 20;
      for (k = 0; k < 20; k++) hot_pages[k] = PageW'($urandom_range(255));
      n = 80;
      for (k = 0; k < n; k++) begin
        if ($urandom_range(99) < 75)
          enqueue(hot_pages[$urandom_range(hot_count - 1)]);
        else
          enqueue(PageW'($urandom_range(255)));
      end
      drain();
    end

    idle_pct = 0;
    stall_pct = 0;
    drain();
    errors += pending_results.size();
    if (errors == 0)
      $display("fifo_page_replacement_test: done, clean");
    else
      $display("fifo_page_replacement_test: done, errors");
    $finish;
  end

endmodule
